FILE: rtl/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    localparam int CAPACITY   = 16;
    localparam int VALUE_BITS = 32;
    localparam int COUNT_BITS = $clog2(CAPACITY + 1);

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [COUNT_BITS-1:0]        t_count;

    typedef enum logic [1:0] {
        ACT_INSERT = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_PEEK   = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } t_status;

    // per-beat control broadcast to every cell
    typedef struct packed {
        logic do_insert;
        logic do_remove;
    } t_cell_ctl;

endpackage

FILE: rtl/spq_cell.sv
`timescale 1ns / 1ps

module spq_cell import spq_pkg::*; (
    input  logic      i_clk,
    input  t_cell_ctl i_ctl,
    input  t_value    i_key,
    input  logic      i_occupied,
    input  logic      i_left_gt,
    input  t_value    i_left_value,
    input  t_value    i_right_value,
    output t_value    o_value,
    output logic      o_gt
);

    t_value r_value;
    t_value n_value;

    // new key goes at or above this slot
    assign o_gt = !i_occupied || (i_key > r_value);

    always_comb begin
        n_value = r_value;
        if (i_ctl.do_insert && o_gt) begin
            // displaced from the left, or the key lands here
            n_value = i_left_gt ? i_left_value : i_key;
        end else if (i_ctl.do_remove) begin
            n_value = i_right_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_value = r_value;

endmodule

FILE: rtl/sorted_priority_queue.sv
`timescale 1ns / 1ps

// channel   | direction | handshake         | beat fields
// ----------+-----------+-------------------+----------------------------------
// command   | in        | i_start, o_busy   | i_action, i_value
// result    | out       | o_strobe          | o_result_value, o_status,
//           |           |                   | o_occupancy
//
// one command per cycle; its result appears on the cycle after it is taken
// every cell updates in the same cycle, so the chain of compare cells sets the
// clock path: one compare plus a two-way select per slot
// i_rst_n is synchronous active low and empties the queue (slot contents stay)
// o_busy is always low; the result side has no back pressure and needs none

module sorted_priority_queue import spq_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    output logic                  o_busy,
    input  logic [1:0]            i_action,
    input  logic signed [VALUE_BITS-1:0] i_value,
    output logic                  o_strobe,
    output logic signed [VALUE_BITS-1:0] o_result_value,
    output logic [1:0]            o_status,
    output logic [COUNT_BITS-1:0] o_occupancy
);

    // number of held entries; slots below it are valid, sorted descending
    t_count r_count;
    t_count n_count;

    // registered result beat
    logic    r_strobe;
    t_value  r_result;
    t_status r_status;
    t_count  r_occ;
    t_value  n_result;
    t_status n_status;

    t_cell_ctl w_ctl;
    t_value    w_val [CAPACITY];
    logic      w_gt  [CAPACITY];

    logic w_accept;
    logic w_full;
    logic w_empty;

    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign w_full   = (r_count == t_count'(CAPACITY));
    assign w_empty  = (r_count == '0);

    // decode the command and work out the result beat
    always_comb begin
        w_ctl    = '0;
        n_count  = r_count;
        n_result = '0;
        n_status = ST_OK;
        unique case (i_action)
            ACT_INSERT: begin
                if (w_full) begin
                    n_status = ST_OVERFLOW;
                end else begin
                    w_ctl.do_insert = w_accept;
                    n_count         = r_count + t_count'(1);
                end
            end
            ACT_REMOVE: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    w_ctl.do_remove = w_accept;
                    n_result        = w_val[0];
                    n_count         = r_count - t_count'(1);
                end
            end
            ACT_PEEK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_result = w_val[0];
                end
            end
            default: begin
                // unused action code: nothing changes
            end
        endcase
    end

    // the sorted chain: each cell compares the key with its own slot and
    // takes its left neighbor or the key on insert, its right neighbor on remove
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic   w_left_gt;
        t_value w_left_val;
        t_value w_right_val;

        if (g == 0) begin : g_head
            assign w_left_gt  = 1'b0;
            assign w_left_val = i_value;
        end else begin : g_body
            assign w_left_gt  = w_gt[g-1];
            assign w_left_val = w_val[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            assign w_right_val = w_val[g];
        end else begin : g_inner
            assign w_right_val = w_val[g+1];
        end

        spq_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_key         (i_value),
            .i_occupied    (r_count > t_count'(g)),
            .i_left_gt     (w_left_gt),
            .i_left_value  (w_left_val),
            .i_right_value (w_right_val),
            .o_value       (w_val[g]),
            .o_gt          (w_gt[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= w_accept;
            if (w_accept) begin
                r_count <= n_count;
            end
        end
    end

    // payload of the result beat, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_result <= n_result;
            r_status <= n_status;
            r_occ    <= n_count;
        end
    end

    assign o_strobe       = r_strobe;
    assign o_result_value = r_result;
    assign o_status       = r_status;
    assign o_occupancy    = r_occ;

    // count never passes capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(CAPACITY))
        else $error("entry count above capacity");

    // the two front slots stay in descending order
    a_head_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count >= t_count'(2) |-> w_val[0] >= w_val[1])
        else $error("front slots out of order");

    // every taken command gives a result beat on the next cycle
    a_beat_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_strobe)
        else $error("missing result beat");

    // overflow only reported for a full queue
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_status == ST_OVERFLOW |-> o_occupancy == t_count'(CAPACITY))
        else $error("overflow on a queue that was not full");

endmodule
